// File: sv/acm_pkg.sv
// Shared codes and field widths of the multi-pattern byte matcher.
`default_nettype none
package acm_pkg;
    localparam int ACT_W  = 2;
    localparam int SYM_W  = 8;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 3;
    localparam int POS_W  = 16;
    localparam int LEN_W  = 10;

    typedef enum logic [ACT_W-1:0] {
        ACT_PAT  = 2'd0,
        ACT_END  = 2'd1,
        ACT_TEXT = 2'd2,
        ACT_LINE = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_LATE  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_SAT   = 3'd4
    } t_status;
endpackage
`default_nettype wire

// File: sv/acm_in_if.sv
// Input word channel: action, symbol and pattern tag.
`default_nettype none
interface acm_in_if import acm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SYM_W-1:0] symbol;
    logic [TAG_W-1:0] pattern_tag;

    modport source(output valid, action, symbol, pattern_tag, input ready);
    modport sink(input valid, action, symbol, pattern_tag, output ready);
endinterface
`default_nettype wire

// File: sv/acm_out_if.sv
// Result word channel: status and match report.
`default_nettype none
interface acm_out_if import acm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              match_found;
    logic [POS_W-1:0]  match_start;
    logic [LEN_W-1:0]  match_length;
    logic [TAG_W-1:0]  match_tag;

    modport source(output valid, status, match_found, match_start, match_length, match_tag,
                   input ready);
    modport sink(input valid, status, match_found, match_start, match_length, match_tag,
                 output ready);
endinterface
`default_nettype wire

// File: sv/acm_ram.sv
// Single write port, single read port RAM with registered read data.
`default_nettype none
module acm_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/multi_pattern_byte_matcher.sv
// Multi-pattern byte matcher (Aho-Corasick style). Pattern bytes build a byte trie in
// the child memory (one entry per node and symbol); an end word tags the node reached.
// The first text byte triggers a failure-link build: a sweep over all nodes per trie
// level, each link found by walking earlier links through the two memories. Text bytes
// then walk goto edges and failure links; a match is reported only when the node
// reached itself ends a pattern. After reset the child memory is cleared, one entry per
// cycle over all 2**(clog2(MAX_NODES)+clog2(ALPHABET)) entries, with input ready held
// low. The link build sweeps all nodes once per trie level, plus one closing sweep that
// finds no node. All work goes to one read-modify-write sequencer over the two memories,
// so a new input word is taken only once the last one is through. One result word per
// input word; results wait in an output register.
`default_nettype none
module multi_pattern_byte_matcher import acm_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 256,
    parameter int MAX_LINE  = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    acm_in_if.sink    i_in,
    acm_out_if.source o_out
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(ALPHABET);
    localparam int AW = NW + CW;
    localparam int unsigned POS_CAP = (MAX_LINE < 65536) ? MAX_LINE - 1 : 65535;

    typedef struct packed {
        logic              endf;
        logic [TAG_W-1:0]  tag;
        logic [NW-1:0]     depth;
        logic [NW-1:0]     fail;
        logic [NW-1:0]     parent;
        logic [CW-1:0]     chr;
    } t_node;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_P_CHK, S_E_WR, S_B_START, S_B_CHK, S_B_PAR,
        S_ADV_RD, S_ADV_CHK, S_T_CHK, S_OUT
    } t_state;

    // symbol reduced modulo the alphabet, constant table
    logic [CW-1:0] sym_mod_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign sym_mod_tab[g] = CW'(g % ALPHABET);
    end

    // memories
    logic          ch_we;
    logic [AW-1:0] ch_waddr, ch_raddr;
    logic [NW-1:0] ch_wdata, ch_rdata;
    logic          nd_we;
    logic [NW-1:0] nd_waddr, nd_raddr;
    t_node         nd_wdata, nd_rdata, nd_rdata_raw;

    acm_ram #(.AW(AW), .DW(NW)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata)
    );

    acm_ram #(.AW(NW), .DW($bits(t_node))) u_node (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata_raw)
    );

    t_state            r_state, n_state;
    logic [AW:0]       r_clr, n_clr;
    logic [NW:0]       r_node_count, n_node_count;
    logic [NW-1:0]     r_ins, n_ins;
    logic [NW-1:0]     r_match, n_match;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_text_started, n_text_started;
    logic              r_links_ready, n_links_ready;
    logic [CW-1:0]     r_sym, n_sym;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [NW:0]       r_lvl, n_lvl;
    logic [NW:0]       r_v, n_v;
    logic              r_found_lvl, n_found_lvl;
    t_node             r_w, n_w;
    logic [NW-1:0]     r_adv_s, n_adv_s;
    logic [CW-1:0]     r_adv_c, n_adv_c;
    logic              r_adv_build, n_adv_build;
    logic              r_rd_root;
    t_status           r_res_status, n_res_status;
    logic              r_res_found, n_res_found;
    logic [POS_W-1:0]  r_res_start, n_res_start;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic              r_o_valid, n_o_valid;
    t_status           r_o_status, n_o_status;
    logic              r_o_found, n_o_found;
    logic [POS_W-1:0]  r_o_start, n_o_start;
    logic [LEN_W-1:0]  r_o_len, n_o_len;
    logic [TAG_W-1:0]  r_o_tag, n_o_tag;

    logic [CW-1:0]     sym_in;
    logic [POS_W-1:0]  pos_use;
    logic [POS_W:0]    pos1;
    logic [POS_W:0]    d17;

    // root has no stored entry: it reads as all zero
    assign nd_rdata = r_rd_root ? '0 : nd_rdata_raw;
    assign sym_in   = sym_mod_tab[i_in.symbol];

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.match_found  = r_o_found;
    assign o_out.match_start  = r_o_start;
    assign o_out.match_length = r_o_len;
    assign o_out.match_tag    = r_o_tag;

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_node_count   = r_node_count;
        n_ins          = r_ins;
        n_match        = r_match;
        n_pos          = r_pos;
        n_text_started = r_text_started;
        n_links_ready  = r_links_ready;
        n_sym          = r_sym;
        n_tag          = r_tag;
        n_lvl          = r_lvl;
        n_v            = r_v;
        n_found_lvl    = r_found_lvl;
        n_w            = r_w;
        n_adv_s        = r_adv_s;
        n_adv_c        = r_adv_c;
        n_adv_build    = r_adv_build;
        n_res_status   = r_res_status;
        n_res_found    = r_res_found;
        n_res_start    = r_res_start;
        n_res_len      = r_res_len;
        n_res_tag      = r_res_tag;
        n_o_valid      = r_o_valid && !o_out.ready;
        n_o_status     = r_o_status;
        n_o_found      = r_o_found;
        n_o_start      = r_o_start;
        n_o_len        = r_o_len;
        n_o_tag        = r_o_tag;

        ch_we    = 1'b0;
        ch_waddr = {r_ins, r_sym};
        ch_wdata = '0;
        ch_raddr = {r_adv_s, r_adv_c};
        nd_we    = 1'b0;
        nd_waddr = r_ins;
        nd_wdata = nd_rdata;
        nd_raddr = r_adv_s;
        pos_use  = r_pos;
        pos1     = '0;
        d17      = '0;

        unique case (r_state)
            S_CLEAR: begin
                if (r_clr[AW]) begin
                    n_state = S_IDLE;
                end else begin
                    ch_we    = 1'b1;
                    ch_waddr = r_clr[AW-1:0];
                    n_clr    = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                ch_raddr = {r_ins, sym_in};
                nd_raddr = r_ins;
                if (i_in.valid) begin
                    n_sym        = sym_in;
                    n_tag        = i_in.pattern_tag;
                    n_res_status = ST_OK;
                    n_res_found  = 1'b0;
                    n_res_start  = '0;
                    n_res_len    = '0;
                    n_res_tag    = '0;
                    unique case (t_action'(i_in.action))
                        ACT_PAT: begin
                            if (r_text_started) begin
                                n_res_status = ST_LATE;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_P_CHK;
                            end
                        end
                        ACT_END: begin
                            if (r_text_started) begin
                                n_res_status = ST_LATE;
                                n_state      = S_OUT;
                            end else if (r_ins == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_E_WR;
                            end
                        end
                        ACT_TEXT: begin
                            n_text_started = 1'b1;
                            if (!r_links_ready) begin
                                // depth-one nodes already fail to root
                                n_lvl       = (NW+1)'(2);
                                n_v         = (NW+1)'(1);
                                n_found_lvl = 1'b0;
                                n_state     = S_B_START;
                            end else begin
                                n_adv_s     = r_match;
                                n_adv_c     = sym_in;
                                n_adv_build = 1'b0;
                                n_state     = S_ADV_RD;
                            end
                        end
                        ACT_LINE: begin
                            n_match = '0;
                            n_pos   = '0;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_P_CHK: begin
                if (ch_rdata != '0) begin
                    n_ins = ch_rdata;
                end else if (r_node_count >= (NW+1)'(MAX_NODES)) begin
                    n_res_status = ST_FULL;
                end else begin
                    ch_we           = 1'b1;
                    ch_waddr        = {r_ins, r_sym};
                    ch_wdata        = r_node_count[NW-1:0];
                    nd_we           = 1'b1;
                    nd_waddr        = r_node_count[NW-1:0];
                    nd_wdata        = '0;
                    nd_wdata.depth  = nd_rdata.depth + 1'b1;
                    nd_wdata.parent = r_ins;
                    nd_wdata.chr    = r_sym;
                    n_ins           = r_node_count[NW-1:0];
                    n_node_count    = r_node_count + 1'b1;
                end
                n_state = S_OUT;
            end
            S_E_WR: begin
                nd_we         = 1'b1;
                nd_waddr      = r_ins;
                nd_wdata      = nd_rdata;
                nd_wdata.endf = 1'b1;
                nd_wdata.tag  = r_tag;
                n_ins         = '0;
                n_state       = S_OUT;
            end
            S_B_START: begin
                // sweep nodes one level at a time, breadth first
                if (r_v >= r_node_count) begin
                    if (!r_found_lvl) begin
                        n_links_ready = 1'b1;
                        n_adv_s       = r_match;
                        n_adv_c       = r_sym;
                        n_adv_build   = 1'b0;
                        n_state       = S_ADV_RD;
                    end else begin
                        n_lvl       = r_lvl + 1'b1;
                        n_v         = (NW+1)'(1);
                        n_found_lvl = 1'b0;
                    end
                end else begin
                    nd_raddr = r_v[NW-1:0];
                    n_state  = S_B_CHK;
                end
            end
            S_B_CHK: begin
                if ({1'b0, nd_rdata.depth} == r_lvl) begin
                    n_found_lvl = 1'b1;
                    n_w         = nd_rdata;
                    nd_raddr    = nd_rdata.parent;
                    n_state     = S_B_PAR;
                end else begin
                    n_v     = r_v + 1'b1;
                    n_state = S_B_START;
                end
            end
            S_B_PAR: begin
                n_adv_s     = nd_rdata.fail;
                n_adv_c     = r_w.chr;
                n_adv_build = 1'b1;
                n_state     = S_ADV_RD;
            end
            S_ADV_RD: begin
                n_state = S_ADV_CHK;
            end
            S_ADV_CHK: begin
                if (r_adv_s == '0 || ch_rdata != '0) begin
                    if (r_adv_build) begin
                        nd_we         = 1'b1;
                        nd_waddr      = r_v[NW-1:0];
                        nd_wdata      = r_w;
                        nd_wdata.fail = ch_rdata;
                        n_v           = r_v + 1'b1;
                        n_state       = S_B_START;
                    end else begin
                        n_match  = ch_rdata;
                        nd_raddr = ch_rdata;
                        n_state  = S_T_CHK;
                    end
                end else begin
                    n_adv_s = nd_rdata.fail;
                    n_state = S_ADV_RD;
                end
            end
            S_T_CHK: begin
                if (r_pos >= POS_W'(POS_CAP)) begin
                    pos_use      = POS_W'(POS_CAP);
                    n_res_status = ST_SAT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
                pos1 = {1'b0, pos_use} + 1'b1;
                d17  = (POS_W+1)'(nd_rdata.depth);
                if (nd_rdata.endf) begin
                    n_res_found = 1'b1;
                    n_res_start = (d17 > pos1) ? '0 : POS_W'(pos1 - d17);
                    n_res_len   = (d17 > (POS_W+1)'(1023)) ? LEN_W'(1023) : d17[LEN_W-1:0];
                    n_res_tag   = nd_rdata.tag;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_found  = r_res_found;
                    n_o_start  = r_res_start;
                    n_o_len    = r_res_len;
                    n_o_tag    = r_res_tag;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_node_count   <= (NW+1)'(1);
            r_ins          <= '0;
            r_match        <= '0;
            r_pos          <= '0;
            r_text_started <= 1'b0;
            r_links_ready  <= 1'b0;
            r_o_valid      <= 1'b0;
            r_rd_root      <= 1'b1;
        end else begin
            r_state        <= n_state;
            r_clr          <= n_clr;
            r_node_count   <= n_node_count;
            r_ins          <= n_ins;
            r_match        <= n_match;
            r_pos          <= n_pos;
            r_text_started <= n_text_started;
            r_links_ready  <= n_links_ready;
            r_o_valid      <= n_o_valid;
            r_rd_root      <= (nd_raddr == '0);
        end
        r_sym        <= n_sym;
        r_tag        <= n_tag;
        r_lvl        <= n_lvl;
        r_v          <= n_v;
        r_found_lvl  <= n_found_lvl;
        r_w          <= n_w;
        r_adv_s      <= n_adv_s;
        r_adv_c      <= n_adv_c;
        r_adv_build  <= n_adv_build;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_start  <= n_res_start;
        r_res_len    <= n_res_len;
        r_res_tag    <= n_res_tag;
        r_o_status   <= n_o_status;
        r_o_found    <= n_o_found;
        r_o_start    <= n_o_start;
        r_o_len      <= n_o_len;
        r_o_tag      <= n_o_tag;
    end
endmodule
`default_nettype wire
